// ----- rtl/core/tcal_pkg.sv -----
// Shared types and constants for the two-channel alarm latch with event log.
`timescale 1ns / 1ps
`default_nettype none

package tcal_pkg;

  localparam int LOG_DEPTH = 16;
  localparam int LOG_AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int LOG_CW = $clog2(LOG_DEPTH + 1);

  localparam logic [2:0] CMD_UPDATE      = 3'd0;
  localparam logic [2:0] CMD_ACK         = 3'd1;
  localparam logic [2:0] CMD_READ_ACTIVE = 3'd2;
  localparam logic [2:0] CMD_READ_LOG    = 3'd3;
  localparam logic [2:0] CMD_CLEAR_LOG   = 3'd4;

  localparam logic [1:0] LEVEL_NORMAL = 2'd0;
  localparam logic       KIND_TEMP    = 1'b0;
  localparam logic       KIND_VIB     = 1'b1;

  typedef struct packed {
    logic [2:0]  command;
    logic [1:0]  temp_level;
    logic [1:0]  vib_level;
    logic [31:0] now;
    logic [1:0]  sensor_select;
    logic [7:0]  index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  changed_mask;
    logic [1:0]  active_mask;
    logic        ack_ok;
    logic [1:0]  active_count;
    logic [4:0]  log_count;
    logic        entry_valid;
    logic        entry_kind;
    logic [1:0]  entry_level;
    logic [31:0] entry_start;
    logic [31:0] entry_end;
    logic        entry_acked;
  } out_word_t;

  typedef struct packed {
    logic        vld;
    logic        kind;
    logic [1:0]  level;
    logic        acked;
    logic [31:0] start_time;
    logic [31:0] end_time;
  } log_push_t;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [1:0]  level;
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic        acked;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/two_channel_alarm_latch_with_log_unit.sv -----
// Top level of the two-channel alarm latch with event log.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one command word on the input channel and returns one result
// word on the output channel for every command. Update words carry both channel
// levels and a timestamp; acknowledge, read-active, read-log and clear-log words
// use the select and index fields. A cleared alarm is written to a ring log of
// LOG_DEPTH slots, and an update that clears both channels writes two slots.
// An accepted word is held in an input register; the state update
// and the result are then computed in one pass and captured in the output
// register, which drives out_valid. A new word can be accepted in every
// cycle while in_stall is low.
// While out_stall holds the output word, the input register still takes one
// more word; in_stall rises only while both registers are full and out_stall is high.
// Synchronous reset clears the channel state, the log pointer and count, and
// both valid flags. Log slot contents are not reset; slots past the count are
// never returned.
module two_channel_alarm_latch_with_log_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tcal_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tcal_pkg::out_word_t  out_data
);

  logic                      ir_valid_r, ir_valid_nxt;
  tcal_pkg::in_word_t        ir_data_r;
  logic                      out_valid_r, out_valid_nxt;
  tcal_pkg::out_word_t       out_data_r, result;
  logic                      adv, accept;
  tcal_pkg::log_push_t [1:0] push;
  tcal_pkg::entry_t          chan_entry, log_entry, entry;
  logic [1:0]                changed_mask, active_mask, active_count;
  logic                      ack_ok;
  logic [4:0]                log_count;

  assign adv      = ir_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = ir_valid_r && !adv;
  assign accept   = in_valid && !in_stall;

  tcal_chan u_chan (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (adv),
    .item         (ir_data_r),
    .push         (push),
    .changed_mask (changed_mask),
    .active_mask  (active_mask),
    .ack_ok       (ack_ok),
    .active_count (active_count),
    .entry        (chan_entry)
  );

  tcal_log u_log (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .push      (push),
    .clear     (ir_data_r.command == tcal_pkg::CMD_CLEAR_LOG),
    .rd        (ir_data_r.command == tcal_pkg::CMD_READ_LOG),
    .index     (ir_data_r.index),
    .log_count (log_count),
    .entry     (log_entry)
  );

  always_comb begin
    if (ir_data_r.command == tcal_pkg::CMD_READ_ACTIVE) begin
      entry = chan_entry;
    end else begin
      entry = log_entry;
    end
    result.changed_mask = changed_mask;
    result.active_mask  = active_mask;
    result.ack_ok       = ack_ok;
    result.active_count = active_count;
    result.log_count    = log_count;
    result.entry_valid  = entry.valid;
    result.entry_kind   = entry.kind;
    result.entry_level  = entry.level;
    result.entry_start  = entry.start_time;
    result.entry_end    = entry.end_time;
    result.entry_acked  = entry.acked;
  end

  always_comb begin
    if (accept) begin
      ir_valid_nxt = 1'b1;
    end else begin
      ir_valid_nxt = ir_valid_r && !adv;
    end
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ir_valid_r  <= ir_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ir_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/core/tcal_chan.sv -----
// Alarm channel state for temperature and vibration, with update, acknowledge and read logic.
`timescale 1ns / 1ps
`default_nettype none

module tcal_chan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  tcal_pkg::in_word_t            item,
  output tcal_pkg::log_push_t [1:0]     push,
  output logic [1:0]                    changed_mask,
  output logic [1:0]                    active_mask,
  output logic                          ack_ok,
  output logic [1:0]                    active_count,
  output tcal_pkg::entry_t              entry
);

  logic [1:0]       raised_r, raised_nxt;
  logic [1:0]       acked_r, acked_nxt;
  logic [1:0][1:0]  level_r, level_nxt;
  logic [1:0][31:0] start_r, start_nxt;
  logic [1:0][1:0]  lvl_in;
  logic             sel;

  always_comb begin
    raised_nxt   = raised_r;
    acked_nxt    = acked_r;
    level_nxt    = level_r;
    start_nxt    = start_r;
    changed_mask = 2'b00;
    ack_ok       = 1'b0;
    push         = '0;
    entry        = '0;
    lvl_in[0]    = item.temp_level;
    lvl_in[1]    = item.vib_level;
    sel          = item.sensor_select[0];
    unique case (item.command)
      tcal_pkg::CMD_UPDATE: begin
        for (int ch = 0; ch < 2; ch++) begin
          if (lvl_in[ch] != tcal_pkg::LEVEL_NORMAL) begin
            if (!raised_r[ch]) begin
              raised_nxt[ch]   = 1'b1;
              level_nxt[ch]    = lvl_in[ch];
              start_nxt[ch]    = item.now;
              acked_nxt[ch]    = 1'b0;
              changed_mask[ch] = 1'b1;
            end else if (lvl_in[ch] > level_r[ch]) begin
              level_nxt[ch]    = lvl_in[ch];
              changed_mask[ch] = 1'b1;
            end
          end else if (raised_r[ch]) begin
            push[ch].vld        = 1'b1;
            push[ch].kind       = 1'(ch);
            push[ch].level      = level_r[ch];
            push[ch].acked      = acked_r[ch];
            push[ch].start_time = start_r[ch];
            push[ch].end_time   = item.now;
            raised_nxt[ch]      = 1'b0;
            level_nxt[ch]       = tcal_pkg::LEVEL_NORMAL;
            changed_mask[ch]    = 1'b1;
          end
        end
      end
      tcal_pkg::CMD_ACK: begin
        if (!item.sensor_select[1] && raised_r[sel] && !acked_r[sel]) begin
          acked_nxt[sel] = 1'b1;
          ack_ok         = 1'b1;
        end
      end
      tcal_pkg::CMD_READ_ACTIVE: begin
        if (item.index == 8'd0 && raised_r[0]) begin
          entry.valid      = 1'b1;
          entry.kind       = tcal_pkg::KIND_TEMP;
          entry.level      = level_r[0];
          entry.start_time = start_r[0];
          entry.acked      = acked_r[0];
        end else if ((item.index == 8'd0 && raised_r == 2'b10) ||
                     (item.index == 8'd1 && raised_r == 2'b11)) begin
          entry.valid      = 1'b1;
          entry.kind       = tcal_pkg::KIND_VIB;
          entry.level      = level_r[1];
          entry.start_time = start_r[1];
          entry.acked      = acked_r[1];
        end
      end
      default: begin
      end
    endcase
    active_mask  = raised_nxt;
    active_count = {1'b0, raised_nxt[0]} + {1'b0, raised_nxt[1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raised_r <= '0;
      acked_r  <= '0;
      level_r  <= '0;
      start_r  <= '0;
    end else if (en) begin
      raised_r <= raised_nxt;
      acked_r  <= acked_nxt;
      level_r  <= level_nxt;
      start_r  <= start_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tcal_log.sv -----
// Ring log of cleared alarms with write pointer, saturating count and slot read.
`timescale 1ns / 1ps
`default_nettype none

module tcal_log (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  tcal_pkg::log_push_t [1:0] push,
  input  logic                      clear,
  input  logic                      rd,
  input  logic [7:0]                index,
  output logic [4:0]                log_count,
  output tcal_pkg::entry_t          entry
);

  localparam int AW = tcal_pkg::LOG_AW;
  localparam int CW = tcal_pkg::LOG_CW;
  localparam int DEPTH = tcal_pkg::LOG_DEPTH;

  logic [DEPTH-1:0][31:0] start_r;
  logic [DEPTH-1:0][31:0] end_r;
  logic [DEPTH-1:0][1:0]  level_r;
  logic [DEPTH-1:0]       kind_r;
  logic [DEPTH-1:0]       acked_r;
  logic [AW-1:0]          ptr_r, ptr_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt, cnt_mid;
  logic [AW-1:0]          addr0, addr1, rd_addr;
  logic                   rd_ok;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] q;
    if (p == AW'(DEPTH - 1)) begin
      q = '0;
    end else begin
      q = p + AW'(1);
    end
    return q;
  endfunction

  always_comb begin
    addr0   = ptr_r;
    addr1   = push[0].vld ? ptr_inc(ptr_r) : ptr_r;
    cnt_mid = (push[0].vld && cnt_r < CW'(DEPTH)) ? cnt_r + CW'(1) : cnt_r;
    if (clear) begin
      ptr_nxt = '0;
      cnt_nxt = '0;
    end else begin
      ptr_nxt = push[1].vld ? ptr_inc(addr1) : addr1;
      cnt_nxt = (push[1].vld && cnt_mid < CW'(DEPTH)) ? cnt_mid + CW'(1) : cnt_mid;
    end
    log_count = 5'(cnt_nxt);
  end

  always_comb begin
    rd_addr = index[AW-1:0];
    rd_ok   = rd && (9'(index) < 9'(cnt_r));
    entry   = '0;
    if (rd_ok) begin
      entry.valid      = 1'b1;
      entry.kind       = kind_r[rd_addr];
      entry.level      = level_r[rd_addr];
      entry.start_time = start_r[rd_addr];
      entry.end_time   = end_r[rd_addr];
      entry.acked      = acked_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      cnt_r <= '0;
    end else if (en) begin
      ptr_r <= ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && push[0].vld) begin
      start_r[addr0] <= push[0].start_time;
      end_r[addr0]   <= push[0].end_time;
      level_r[addr0] <= push[0].level;
      kind_r[addr0]  <= push[0].kind;
      acked_r[addr0] <= push[0].acked;
    end
    if (en && push[1].vld) begin
      start_r[addr1] <= push[1].start_time;
      end_r[addr1]   <= push[1].end_time;
      level_r[addr1] <= push[1].level;
      kind_r[addr1]  <= push[1].kind;
      acked_r[addr1] <= push[1].acked;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tcal_chk.sv -----
// Port-level checker for the alarm latch top level, with its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module tcal_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input tcal_pkg::out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled output word changed or was dropped.");

  a_count_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.active_count == 2'($countones(out_data.active_mask)))
    else $error("Active count does not match the active mask.");

  a_log_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.log_count) <= 32'(tcal_pkg::LOG_DEPTH))
    else $error("Log count exceeds the log depth.");

  a_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.entry_valid |-> out_data.entry_start == 32'd0 &&
      out_data.entry_end == 32'd0 && out_data.entry_level == 2'd0 &&
      !out_data.entry_kind && !out_data.entry_acked)
    else $error("Entry fields are set on a word without a valid entry.");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Output valid after reset.");

endmodule

bind two_channel_alarm_latch_with_log_unit tcal_chk u_tcal_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
